@@ src/differential_drive_odometry_macros.svh @@
// Assertion macros shared by the odometry checker.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// Check a property on the rising clock edge, skipped while in reset.
`define DDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, also during reset.
`define DDO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/ddo_pkg.sv @@
// Shared constants, types and tables of the odometry block.
`timescale 1ns / 1ps
package ddo_pkg;

    localparam int ANGLE_BITS_DEF   = 24;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam int NUM_W  = 63;  // dividend of the heading step
    localparam int SUM_W  = 34;  // wheel delta sum and difference
    localparam int XY_W   = 34;  // CORDIC vector
    localparam int Z_W    = 33;  // CORDIC residual angle
    localparam int PROD_W = 68;  // step times trig product
    localparam int POS_W  = 48;
    localparam int IN_W   = 64;

    localparam logic [15:0]              WHEEL_BASE_RST = 16'd400;
    localparam logic [29:0]              INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic signed [XY_W-1:0]   CORDIC_GAIN    = 34'sd652032874;
    localparam logic signed [POS_W-1:0]  POS_MAX        = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [POS_W-1:0]  POS_MIN        = 48'sh8000_0000_0000;

    typedef struct packed {
        logic       take;       // capture counts, form deltas
        logic       mul;        // form dividend, clear remainder
        logic       div_step;
        logic       head;
        logic       cord_init;
        logic       cord_step;
        logic [4:0] iter;
        logic       trig;
        logic       pp_en;
        logic       pp_hi;
        logic       pp_y;
        logic       acc_en;
        logic       acc_y;
        logic       out_load;
    } t_cmd;

    // arctangent of 2^-i in 2^32 units per turn, truncated
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051D;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2E;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2F9;
            5'd15: v = 30'h0000517C;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A2F;
            5'd19: v = 30'h00000517;
            5'd20: v = 30'h0000028B;
            5'd21: v = 30'h00000145;
            5'd22: v = 30'h000000A2;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000028;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000002;
            5'd29: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ src/differential_drive_odometry.sv @@
// Top level of the differential drive dead-reckoning odometry block.
// Usage:
//   Slave stream i_s_*: one transaction carries absolute left and right
//   wheel counts in mm. Master stream o_m_*: one transaction carries the
//   updated x, y position (1/2^FRAC_BITS mm) and binary-angle heading.
//   Config channel i_cfg_*: writes the wheel base in mm, always ready;
//   write it only while the block is idle.
// Operation:
//   The first sample after reset only primes the counts and gives no result.
//   Each later sample runs a bit-serial 63-step heading divider and a
//   CORDIC_STEPS-step iterative CORDIC, then four partial products on a
//   shared 34x18 multiplier; the next sample is taken only after the result
//   is loaded into the output register.
// Reset:
//   Synchronous, active low; clears position, heading and the last counts,
//   and sets the wheel base to 400 mm.
// Stall:
//   A result waits in the output register while the next sample is worked
//   on; the block holds its last step until that register is taken.
`timescale 1ns / 1ps
module differential_drive_odometry #(
    parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
    localparam int OUT_W       = ((2 * ddo_pkg::POS_W + ANGLE_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // left_count [31:0], right_count [63:32]
    input  logic [ddo_pkg::IN_W-1:0] i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // pos_x [47:0], pos_y [95:48], heading_angle above, zero fill
    output logic [OUT_W-1:0]         o_m_tdata,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [15:0]              i_cfg_data
);
    import ddo_pkg::*;

    t_cmd                    w_cmd;
    logic signed [POS_W-1:0] w_x, w_y;
    logic [ANGLE_BITS-1:0]   w_h;

    assign o_cfg_ready = 1'b1;

    ddo_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_cmd       (w_cmd)
    );

    ddo_dpath #(
        .ANGLE_BITS(ANGLE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_left     (i_s_tdata[31:0]),
        .i_right    (i_s_tdata[63:32]),
        .o_pos_x    (w_x),
        .o_pos_y    (w_y),
        .o_heading  (w_h)
    );

    assign o_m_tdata = OUT_W'({w_h, w_y, w_x});

endmodule

@@ src/ddo_ctrl.sv @@
// Sequencer of the odometry block: handshakes and datapath commands.
`timescale 1ns / 1ps
module ddo_ctrl #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output ddo_pkg::t_cmd o_cmd
);
    import ddo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV, S_HEAD, S_CINIT, S_CORD, S_TRIG,
        S_PX0, S_PX1, S_AX, S_PY0, S_PY1, S_AY, S_FIN
    } t_state;

    t_state     r_state;
    logic [5:0] r_cnt;
    logic       r_primed;
    logic       r_out_valid;
    logic       w_in_acc;
    logic       w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.iter     = r_cnt[4:0];
        o_cmd.take     = w_in_acc;
        unique case (r_state)
            S_IDLE:  ;
            S_MUL:   o_cmd.mul = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_HEAD:  o_cmd.head = 1'b1;
            S_CINIT: o_cmd.cord_init = 1'b1;
            S_CORD:  o_cmd.cord_step = 1'b1;
            S_TRIG:  o_cmd.trig = 1'b1;
            S_PX0:   o_cmd.pp_en = 1'b1;
            S_PX1: begin
                o_cmd.pp_en = 1'b1;
                o_cmd.pp_hi = 1'b1;
            end
            S_AX:    o_cmd.acc_en = 1'b1;
            S_PY0: begin
                o_cmd.pp_en = 1'b1;
                o_cmd.pp_y  = 1'b1;
            end
            S_PY1: begin
                o_cmd.pp_en = 1'b1;
                o_cmd.pp_hi = 1'b1;
                o_cmd.pp_y  = 1'b1;
            end
            S_AY: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.acc_y  = 1'b1;
            end
            S_FIN:   o_cmd.out_load = w_slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // raise the result as it is loaded, drop it once taken
            if (r_state == S_FIN && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_primed <= 1'b1;
                        // first sample only primes the counts
                        if (r_primed) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(NUM_W - 1)) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD:  r_state <= S_CINIT;
                S_CINIT: begin
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(CORDIC_STEPS - 1)) begin
                        r_state <= S_TRIG;
                    end
                end
                S_TRIG: r_state <= S_PX0;
                S_PX0:  r_state <= S_PX1;
                S_PX1:  r_state <= S_AX;
                S_AX:   r_state <= S_PY0;
                S_PY0:  r_state <= S_PY1;
                S_PY1:  r_state <= S_AY;
                S_AY:   r_state <= S_FIN;
                S_FIN: begin
                    // hold until the output register is free
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/ddo_dpath.sv @@
// Datapath of the odometry block: deltas, divider, CORDIC, accumulators.
`timescale 1ns / 1ps
module ddo_dpath #(
    parameter int ANGLE_BITS = ddo_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ddo_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ddo_pkg::t_cmd                 i_cmd,
    input  logic                          i_cfg_we,
    input  logic [15:0]                   i_cfg_data,
    input  logic [31:0]                   i_left,
    input  logic [31:0]                   i_right,
    output logic signed [ddo_pkg::POS_W-1:0] o_pos_x,
    output logic signed [ddo_pkg::POS_W-1:0] o_pos_y,
    output logic [ANGLE_BITS-1:0]         o_heading
);
    import ddo_pkg::*;

    localparam int DEN_W = 48 - ANGLE_BITS;
    localparam int SH    = 31 - FRAC_BITS;
    localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) <<< (SH - 1);
    localparam logic signed [PROD_W:0]   SAT_HI = (PROD_W+1)'(POS_MAX);
    localparam logic signed [PROD_W:0]   SAT_LO = (PROD_W+1)'(POS_MIN);

    logic [15:0]              r_wb;
    logic [31:0]              r_prev_l, r_prev_r;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_neg;
    logic [32:0]              r_mag;
    logic [DEN_W-1:0]         r_den;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_rem;
    logic [ANGLE_BITS-1:0]    r_quo;
    logic [ANGLE_BITS-1:0]    r_head;
    logic [1:0]               r_quad;
    logic signed [XY_W-1:0]   r_cx, r_cy, r_c, r_s;
    logic signed [Z_W-1:0]    r_cz;
    logic signed [PROD_W-1:0] r_pp;
    logic signed [POS_W-1:0]  r_acc_x, r_acc_y;
    logic signed [POS_W-1:0]  r_out_x, r_out_y;
    logic [ANGLE_BITS-1:0]    r_out_h;

    logic signed [SUM_W-1:0]  w_dl, w_dr, w_diff;
    logic [15:0]              w_wb_eff;
    logic [NUM_W-1:0]         w_prod;
    logic [DEN_W:0]           w_rsh;
    logic                     w_ge;
    logic [ANGLE_BITS-1:0]    w_step;
    logic [31:0]              w_a32, w_rot, w_r;
    logic signed [XY_W-1:0]   w_xs, w_ys, w_t;
    logic signed [Z_W-1:0]    w_at;
    logic signed [17:0]       w_opnd;
    logic signed [51:0]       w_mult;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [POS_W-1:0]  w_base;
    logic signed [PROD_W:0]   w_acc;
    logic signed [POS_W-1:0]  w_sat;

    // modular 32-bit deltas, seen as signed
    assign w_dl   = SUM_W'($signed(i_left - r_prev_l));
    assign w_dr   = SUM_W'($signed(i_right - r_prev_r));
    assign w_diff = w_dr - w_dl;
    assign w_wb_eff = (r_wb == 16'd0) ? 16'd1 : r_wb;

    assign w_prod = r_mag * INV_TWO_PI_Q32;
    assign w_rsh  = {r_rem, r_num[NUM_W-1]};
    assign w_ge   = (w_rsh >= {1'b0, r_den});
    assign w_step = r_neg ? (ANGLE_BITS'(0) - r_quo) : r_quo;

    assign w_a32 = 32'(r_head) << (32 - ANGLE_BITS);
    assign w_rot = w_a32 + 32'h2000_0000;
    assign w_r   = w_a32 - {w_rot[31:30], 30'd0};
    assign w_xs  = r_cx >>> i_cmd.iter;
    assign w_ys  = r_cy >>> i_cmd.iter;
    assign w_at  = $signed({3'b000, atan_turn(i_cmd.iter)});

    // trig value split in an unsigned low and a signed high half
    assign w_t    = i_cmd.pp_y ? r_s : r_c;
    assign w_opnd = i_cmd.pp_hi ? 18'($signed(w_t[33:17])) : $signed({1'b0, w_t[16:0]});
    assign w_mult = r_sum * w_opnd;

    assign w_rnd  = (r_pp + RND) >>> SH;
    assign w_base = i_cmd.acc_y ? r_acc_y : r_acc_x;
    assign w_acc  = (PROD_W+1)'(w_base) + (PROD_W+1)'(w_rnd);
    assign w_sat  = (w_acc > SAT_HI) ? POS_MAX :
                    (w_acc < SAT_LO) ? POS_MIN : w_acc[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb     <= WHEEL_BASE_RST;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_head   <= '0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wb <= i_cfg_data;
            end
            if (i_cmd.take) begin
                r_prev_l <= i_left;
                r_prev_r <= i_right;
            end
            if (i_cmd.head) begin
                r_head <= r_head + w_step;
            end
            if (i_cmd.acc_en && !i_cmd.acc_y) begin
                r_acc_x <= w_sat;
            end
            if (i_cmd.acc_en && i_cmd.acc_y) begin
                r_acc_y <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sum <= w_dl + w_dr;
            r_neg <= w_diff[SUM_W-1];
            r_mag <= w_diff[SUM_W-1] ? 33'(-w_diff) : 33'(w_diff);
            r_den <= DEN_W'(w_wb_eff) << (32 - ANGLE_BITS);
        end
        if (i_cmd.mul) begin
            r_num <= w_prod + NUM_W'(r_den >> 1);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? DEN_W'(w_rsh - {1'b0, r_den}) : w_rsh[DEN_W-1:0];
            r_num <= r_num << 1;
            r_quo <= {r_quo[ANGLE_BITS-2:0], w_ge};
        end
        if (i_cmd.cord_init) begin
            r_quad <= w_rot[31:30];
            r_cz   <= Z_W'($signed(w_r));
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
        end
        if (i_cmd.cord_step) begin
            if (!r_cz[Z_W-1]) begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_at;
            end else begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_at;
            end
        end
        if (i_cmd.trig) begin
            case (r_quad)
                2'd0: begin
                    r_c <= r_cx;
                    r_s <= r_cy;
                end
                2'd1: begin
                    r_c <= -r_cy;
                    r_s <= r_cx;
                end
                2'd2: begin
                    r_c <= -r_cx;
                    r_s <= -r_cy;
                end
                default: begin
                    r_c <= r_cy;
                    r_s <= -r_cx;
                end
            endcase
        end
        if (i_cmd.pp_en) begin
            r_pp <= i_cmd.pp_hi ? (r_pp + (PROD_W'(w_mult) <<< 17)) : PROD_W'(w_mult);
        end
        if (i_cmd.out_load) begin
            r_out_x <= r_acc_x;
            r_out_y <= r_acc_y;
            r_out_h <= r_head;
        end
    end

    assign o_pos_x   = r_out_x;
    assign o_pos_y   = r_out_y;
    assign o_heading = r_out_h;

endmodule

@@ src/ddo_checker.sv @@
// Port-level checker of the odometry block, bound to the top level.
`timescale 1ns / 1ps
`include "differential_drive_odometry_macros.svh"
module ddo_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic o_m_tvalid,
    input logic i_m_tready
);
    // a stalled result stays offered
    `DDO_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")

    // reset empties the output register
    `DDO_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    // a result never appears right after an input transaction
    `DDO_ASSERT(a_no_quick, $rose(o_m_tvalid) |-> !$past(i_s_tvalid && o_s_tready), "result too early")

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);

@@ verif/tb_differential_drive_odometry.sv @@
// Self-checking testbench for the differential drive odometry block.
`timescale 1ns / 1ps
module tb_differential_drive_odometry;

    localparam int OUT_W      = 120;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 110;  // one full update plus margin

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic [23:0]        heading;
    } t_pose;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [63:0]       i_s_tdata;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [OUT_W-1:0]  o_m_tdata;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [15:0]       i_cfg_data;

    differential_drive_odometry u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // arctangent of 2^-i, 2^32 units per turn, truncated
    localparam longint ATAN_TURN [24] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
        64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };
    localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POS_LO = -64'sh0000_8000_0000_0000;

    // predictor state
    logic [15:0] wheel_base;
    logic [31:0] last_left, last_right;
    logic        primed;
    longint      track_x, track_y;
    logic [23:0] track_heading;
    t_pose       pose_queue[$];

    int          errors;
    bit          quiet;        // no idling on either side
    int          holdoff_req;  // receiver hold-off request, in cycles
    logic [31:0] cnt_left, cnt_right;

    function automatic longint clamp_pos(input longint v);
        if (v > POS_HI) return POS_HI;
        if (v < POS_LO) return POS_LO;
        return v;
    endfunction

    function automatic longint scale_step(input longint sum, input longint trig);
        return (sum * trig + (64'sd1 <<< 14)) >>> 15;
    endfunction

    function void predict_pose(input logic [31:0] left, input logic [31:0] right);
        logic [31:0] dl32, dr32, a32, rem;
        longint      dl, dr, diff, sum, cx, sy, x, y, z, nx;
        logic [63:0] mag, den, quo;
        logic [23:0] turn;
        logic [1:0]  quad;
        if (!primed) begin
            last_left = left;
            last_right = right;
            primed = 1'b1;
            return;
        end
        dl32 = left - last_left;
        dr32 = right - last_right;
        dl = $signed(dl32);
        dr = $signed(dr32);
        last_left = left;
        last_right = right;
        diff = dr - dl;
        mag = (diff < 0) ? -diff : diff;
        den = {48'd0, (wheel_base == 16'd0) ? 16'd1 : wheel_base} << 8;
        quo = (mag * 64'd683565276 + den / 2) / den;
        turn = quo[23:0];
        if (diff < 0) turn = -turn;
        track_heading = track_heading + turn;

        // reduce to +-1/8 turn, rotate, then restore the quadrant
        a32 = {track_heading, 8'd0};
        quad = 2'((a32 + 32'h2000_0000) >> 30);
        rem = a32 - {quad, 30'd0};
        z = $signed(rem);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_TURN[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_TURN[i];
            end
            x = nx;
        end
        case (quad)
            2'd0: begin cx = x;  sy = y;  end
            2'd1: begin cx = -y; sy = x;  end
            2'd2: begin cx = -x; sy = -y; end
            default: begin cx = y; sy = -x; end
        endcase
        sum = dl + dr;
        track_x = clamp_pos(track_x + scale_step(sum, cx));
        track_y = clamp_pos(track_y + scale_step(sum, sy));
        pose_queue.push_back('{track_x[47:0], track_y[47:0], track_heading});
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver: random stall bursts and a requested long hold-off
    int stall_left;
    initial begin
        i_m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req > 0) begin
                i_m_tready = 1'b0;
                holdoff_req--;
            end else if (stall_left > 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_m_tready = 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest expected pose
    always @(posedge i_clk) begin
        t_pose got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata[47:0], o_m_tdata[95:48], o_m_tdata[119:96]};
            if (pose_queue.size() == 0) begin
                $display("%0t: unexpected result x %h y %h heading %h",
                         $time, got.pos_x, got.pos_y, got.heading);
                errors++;
            end else begin
                want = pose_queue.pop_front();
                if (got.pos_x !== want.pos_x) begin
                    $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, got.pos_x);
                    errors++;
                end
                if (got.pos_y !== want.pos_y) begin
                    $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, got.pos_y);
                    errors++;
                end
                if (got.heading !== want.heading) begin
                    $display("%0t: heading expected %h actual %h",
                             $time, want.heading, got.heading);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results pending", pose_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_counts(input logic [31:0] left, input logic [31:0] right);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = {right, left};
        forever begin
            @(posedge i_clk);
            if (o_s_tready) break;
        end
        predict_pose(left, right);
        cnt_left = left;
        cnt_right = right;
    endtask

    // advance the wheel counters by the given deltas
    task automatic move(input logic [31:0] dl, input logic [31:0] dr);
        send_counts(cnt_left + dl, cnt_right + dr);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        wait (pose_queue.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_wheel_base(input logic [15:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        wheel_base = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_first_sample();
        send_counts(32'd5, -32'sd7);     // primes only
        move(32'd100, 32'd100);
        move(32'd0, 32'd0);
    endtask

    task automatic test_turns();
        move(32'h8000_0000, 32'h7FFF_FFFF);  // widest wheel difference
        move(32'h7FFF_FFFF, 32'h8000_0000);
        move(-32'sd200, 32'd200);            // spin in place
        move(32'd300, -32'sd300);
        move(32'd1, 32'd0);
        move(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // count wrap, reverse
        send_counts(32'h7FFF_FFF0, 32'h7FFF_FFF0);
        move(32'd40, 32'd40);                // wrap across the sign boundary
        for (int k = 0; k < 4; k++) move(32'd0, 32'd629);
    endtask

    task automatic test_saturation();
        for (int k = 0; k < 6; k++) move(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        for (int k = 0; k < 12; k++) move(32'h8000_0000, 32'h8000_0000);
        for (int k = 0; k < 6; k++) move(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    task automatic test_wheel_base();
        logic [15:0] bases [4] = '{16'd0, 16'd1, 16'd65535, 16'd400};
        foreach (bases[b]) begin
            write_wheel_base(bases[b]);
            move(32'd50, -32'sd50);
            move(32'h8000_0000, 32'h7FFF_FFFF);
            move(32'd17, 32'd9);
        end
    endtask

    task automatic test_backpressure();
        holdoff_req = 500;
        for (int k = 0; k < 8; k++) move($urandom_range(0, 500), $urandom_range(0, 500));
        drain();
        for (int k = 0; k < 4; k++) move($urandom_range(0, 500), $urandom_range(0, 500));
    endtask

    task automatic random_moves(input int count);
        int kind;
        logic [31:0] d;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                move(32'($urandom_range(0, 6000)) - 32'd3000,
                     32'($urandom_range(0, 6000)) - 32'd3000);
            end else if (kind == 6) begin
                d = 32'($urandom_range(0, 20000)) - 32'd10000;
                move(d, d);
            end else if (kind == 7) begin
                d = 32'($urandom_range(0, 2000)) - 32'd1000;
                move(d, -d);
            end else begin
                send_counts($urandom, $urandom);
            end
        end
    endtask

    task automatic test_random();
        random_moves(450);
        write_wheel_base($urandom_range(1, 2000));
        random_moves(450);
        write_wheel_base(16'($urandom));
        random_moves(450);
        write_wheel_base(16'd400);
        quiet = 1'b1;
        random_moves(250);
    endtask

    initial begin
        errors = 0;
        quiet = 1'b0;
        holdoff_req = 0;
        wheel_base = 16'd400;
        last_left = '0;
        last_right = '0;
        primed = 1'b0;
        track_x = 0;
        track_y = 0;
        track_heading = '0;
        cnt_left = '0;
        cnt_right = '0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_sample();
        test_turns();
        test_saturation();
        test_wheel_base();
        test_backpressure();
        test_random();

        drain();
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
